// File: hdl/tkh_pkg.sv
// Shared types and constants for the top-k min-heap block.
package tkh_pkg;

    localparam int unsigned CAPACITY_DEF = 8;
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned STATUS_W     = 3;
    localparam int unsigned COUNT_W      = 4;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED   = 3'd0,
        ST_REPLACED = 3'd1,
        ST_REJECTED = 3'd2,
        ST_FULL     = 3'd3,
        ST_UNBUILT  = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_BFETCH,
        S_SRD,
        S_SCMP,
        S_DONE
    } t_state;

    // Result handed from the sequencer to the output stage
    typedef struct packed {
        logic                       done;
        t_status                    status;
        logic                       built;
        logic signed [VALUE_W-1:0]  root;
        logic [COUNT_W-1:0]         count;
    } t_res;

endpackage

// File: hdl/top_k_min_heap.sv
// Top level of the top-k min-heap block: sequencer, store and result stage.
//
// Usage: present i_kind, i_value and i_load_last with start while busy is
// low; the item transfers at that clock edge and busy rises the next cycle.
// Each item gives exactly one result: o_done is high for one cycle with
// o_status, o_min_value and o_count; the receiver cannot hold it off.
// A load without last, a rejected offer or an offer to an unbuilt heap
// goes straight to the done state; an offer that replaces the root sifts
// down from the root, visiting at most floor(log2(CAPACITY)) + 1 nodes;
// a load with last builds the heap by sifting down every parent, from the
// last parent to the root. Each level of the sift-down loop reads both
// children from the store (registered read data) and writes one entry back.
// A new item may be started in the cycle o_done is high.
// Reset (synchronous, active low) empties the store, clears the built flag
// and idles the sequencer; store contents are not cleared.
module top_k_min_heap #(
    parameter int unsigned CAPACITY = tkh_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_kind,
    input  logic signed [tkh_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_load_last,
    output logic                               o_done,
    output logic [tkh_pkg::STATUS_W-1:0]       o_status,
    output logic signed [tkh_pkg::VALUE_W-1:0] o_min_value,
    output logic [tkh_pkg::COUNT_W-1:0]        o_count
);
    import tkh_pkg::*;

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                      we;
    logic [IW-1:0]             waddr;
    logic signed [VALUE_W-1:0] wdata;
    logic [IW-1:0]             raddr_a;
    logic [IW-1:0]             raddr_b;
    logic signed [VALUE_W-1:0] rdata_a;
    logic signed [VALUE_W-1:0] rdata_b;
    t_res                      res;

    logic                      r_done;
    logic [STATUS_W-1:0]       r_status;
    logic signed [VALUE_W-1:0] r_min;
    logic [COUNT_W-1:0]        r_count;

    tkh_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .i_load_last (i_load_last),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b),
        .o_res       (res)
    );

    tkh_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= res.done;
        end
    end

    // Result payload; the root reads as zero until the heap is built
    always_ff @(posedge i_clk) begin
        if (res.done) begin
            r_status <= res.status;
            r_min    <= res.built ? res.root : '0;
            r_count  <= res.count;
        end
    end

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_min_value = r_min;
    assign o_count     = r_count;

endmodule

// File: hdl/tkh_mem.sv
// Heap store: one write port, two read ports with registered read data.
module tkh_mem #(
    parameter int unsigned DEPTH = tkh_pkg::CAPACITY_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [tkh_pkg::VALUE_W-1:0] i_wdata,
    input  logic [AW-1:0]                     i_raddr_a,
    input  logic [AW-1:0]                     i_raddr_b,
    output logic signed [tkh_pkg::VALUE_W-1:0] o_rdata_a,
    output logic signed [tkh_pkg::VALUE_W-1:0] o_rdata_b
);
    import tkh_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_q_a;
    logic signed [VALUE_W-1:0] r_q_b;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register both read ports
    always_ff @(posedge i_clk) begin
        r_q_a <= r_mem[i_raddr_a];
        r_q_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_q_a;
    assign o_rdata_b = r_q_b;

endmodule

// File: hdl/tkh_ctrl.sv
// Sequencer for load, heap build and sift-down over the heap store.
module tkh_ctrl #(
    parameter int unsigned CAPACITY = tkh_pkg::CAPACITY_DEF,
    parameter int unsigned IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_kind,
    input  logic signed [tkh_pkg::VALUE_W-1:0] i_value,
    input  logic                              i_load_last,
    output logic                              o_we,
    output logic [IW-1:0]                     o_waddr,
    output logic signed [tkh_pkg::VALUE_W-1:0] o_wdata,
    output logic [IW-1:0]                     o_raddr_a,
    output logic [IW-1:0]                     o_raddr_b,
    input  logic signed [tkh_pkg::VALUE_W-1:0] i_rdata_a,
    input  logic signed [tkh_pkg::VALUE_W-1:0] i_rdata_b,
    output tkh_pkg::t_res                     o_res
);
    import tkh_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned KW = IW + 1;
    localparam int unsigned XW = ((KW > CW) ? KW : CW) + 1;
    localparam int unsigned PW = CW + COUNT_W;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_built, n_built;
    logic                  r_bld,   n_bld;
    logic [IW-1:0]         r_node,  n_node;
    logic [CW-1:0]         r_idx,   n_idx;
    logic signed [VALUE_W-1:0] r_val,  n_val;
    logic signed [VALUE_W-1:0] r_root, n_root;
    t_status               r_status, n_status;

    logic                  accept;
    logic [CW-1:0]         eff_cnt;
    logic                  ld_room;
    logic [CW-1:0]         ld_cnt;
    logic                  off_ok;
    logic                  off_gt;
    logic [KW-1:0]         kid;
    logic [XW-1:0]         kid_x;
    logic [XW-1:0]         kid2_x;
    logic                  kid_in;
    logic                  kid2_in;
    logic                  pick_b;
    logic signed [VALUE_W-1:0] c_val;
    logic [IW-1:0]         c_idx;
    logic                  c_lt;
    logic [CW-1:0]         idx_dec;
    logic [PW-1:0]         cnt_x;

    // Shared decode
    assign accept  = i_start && (r_state == S_IDLE);
    assign eff_cnt = r_built ? '0 : r_count;
    assign ld_room = XW'(eff_cnt) < XW'(CAPACITY);
    assign ld_cnt  = ld_room ? eff_cnt + CW'(1) : eff_cnt;
    assign off_ok  = r_built && (r_count != '0);
    assign off_gt  = r_root < i_value;
    assign idx_dec = r_idx - CW'(1);

    // Children of the current node and the smaller of the two
    assign kid     = {r_node, 1'b1};
    assign kid_x   = XW'(kid);
    assign kid2_x  = kid_x + XW'(1);
    assign kid_in  = kid_x  < XW'(r_count);
    assign kid2_in = kid2_x < XW'(r_count);
    assign pick_b  = kid2_in && (i_rdata_b < i_rdata_a);
    assign c_val   = pick_b ? i_rdata_b : i_rdata_a;
    assign c_idx   = pick_b ? kid2_x[IW-1:0] : kid[IW-1:0];
    assign c_lt    = c_val < r_val;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_kind) begin
                        n_state = i_load_last ? S_BUILD : S_DONE;
                    end else if (off_ok && off_gt) begin
                        n_state = S_SRD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_BUILD:  n_state = (r_idx == '0) ? S_DONE : S_BFETCH;
            S_BFETCH: n_state = S_SRD;
            S_SRD: begin
                if (kid_in) begin
                    n_state = S_SCMP;
                end else begin
                    n_state = r_bld ? S_BUILD : S_DONE;
                end
            end
            S_SCMP: begin
                if (c_lt) begin
                    n_state = S_SRD;
                end else begin
                    n_state = r_bld ? S_BUILD : S_DONE;
                end
            end
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath and store access
    always_comb begin
        n_count   = r_count;
        n_built   = r_built;
        n_bld     = r_bld;
        n_node    = r_node;
        n_idx     = r_idx;
        n_val     = r_val;
        n_root    = r_root;
        n_status  = r_status;
        o_we      = 1'b0;
        o_waddr   = r_node;
        o_wdata   = r_val;
        o_raddr_a = kid[IW-1:0];
        o_raddr_b = kid2_in ? kid2_x[IW-1:0] : kid[IW-1:0];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_kind) begin
                        // Append; a load after the build starts a new store
                        n_built = 1'b0;
                        n_bld   = 1'b1;
                        n_count = ld_cnt;
                        n_idx   = ld_cnt >> 1;
                        if (ld_room) begin
                            o_we     = 1'b1;
                            o_waddr  = eff_cnt[IW-1:0];
                            o_wdata  = i_value;
                            n_status = ST_LOADED;
                        end else begin
                            n_status = ST_FULL;
                        end
                    end else begin
                        n_bld  = 1'b0;
                        n_val  = i_value;
                        n_node = '0;
                        if (!off_ok) begin
                            n_status = ST_UNBUILT;
                        end else if (off_gt) begin
                            n_status = ST_REPLACED;
                        end else begin
                            n_status = ST_REJECTED;
                        end
                    end
                end
            end
            S_BUILD: begin
                // Finish the build or fetch the next parent
                if (r_idx == '0) begin
                    n_built = 1'b1;
                end else begin
                    n_idx     = idx_dec;
                    n_node    = idx_dec[IW-1:0];
                    o_raddr_a = idx_dec[IW-1:0];
                end
            end
            S_BFETCH: begin
                n_val = i_rdata_a;
            end
            S_SRD: begin
                // Leaf reached: drop the carried value into the hole
                if (!kid_in) begin
                    o_we = 1'b1;
                end
            end
            S_SCMP: begin
                // Move the smaller child up, or settle the carried value
                o_we = 1'b1;
                if (c_lt) begin
                    o_wdata = c_val;
                    n_node  = c_idx;
                end
            end
            default: begin
            end
        endcase
        // Track the root entry alongside the store
        if (o_we && (o_waddr == '0)) begin
            n_root = o_wdata;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_built <= 1'b0;
            r_bld   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_built <= n_built;
            r_bld   <= n_bld;
            r_idx   <= n_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_val    <= n_val;
        r_root   <= n_root;
        r_status <= n_status;
    end

    assign cnt_x = PW'(r_count);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_res.done   = (r_state == S_DONE);
        o_res.status = r_status;
        o_res.built  = r_built;
        o_res.root   = r_root;
        o_res.count  = cnt_x[COUNT_W-1:0];
    end

endmodule

// File: hdl/tkh_checker.sv
// Port-level assertions for the top-k min-heap block and their binding.
module tkh_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               i_kind,
    input logic                               i_load_last,
    input logic                               o_done,
    input logic [tkh_pkg::STATUS_W-1:0]       o_status,
    input logic signed [tkh_pkg::VALUE_W-1:0] o_min_value
);
    import tkh_pkg::*;

    // An accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after a transfer");

    // A result appears only once the block has gone idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // Leaving busy always delivers a result
    a_fell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    // A plain load answers as loaded or dropped
    a_load_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_kind && !i_load_last |=> ##1
            (o_done && (o_status == ST_LOADED || o_status == ST_FULL)))
        else $error("plain load result wrong or late");

    // An unbuilt heap reports a zero minimum
    a_unbuilt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_UNBUILT) |-> (o_min_value == '0))
        else $error("unbuilt heap reports a non-zero minimum");

endmodule

bind top_k_min_heap tkh_checker u_tkh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_kind      (i_kind),
    .i_load_last (i_load_last),
    .o_done      (o_done),
    .o_status    (o_status),
    .o_min_value (o_min_value)
);
